// File: hdl/b64d_pkg.sv
// Shared types, constants and the character map for the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

   // Default depth of the queue between the front and back parts
   localparam int B64D_QUEUE_DEPTH = 4;

   // Alphabet boundaries and special characters
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   // Sextet offsets of the lower-case and digit ranges
   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   // Result of mapping one character
   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } b64d_sextet_type;

   // One queue entry: up to three bytes, most significant first
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  count;   // results to emit, 1 to 3
      logic        bare;    // end marker without a byte
      logic        last;    // final result carries message_end
   } b64d_entry_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } b64d_qstat_type;

   // Map an ASCII character to its 6-bit value; '=' and all others are not ok
   function automatic b64d_sextet_type b64d_sextet(input logic [7:0] ch);
      b64d_sextet_type s;
      s.ok    = 1'b1;
      s.value = '0;
      if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         s.value = 6'(ch - CHAR_UPPER_A);
      end else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         s.value = 6'(ch - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
      end else if (ch inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
         s.value = 6'(ch - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
      end else if (ch == CHAR_PLUS) begin
         s.value = SEXTET_PLUS;
      end else if (ch == CHAR_SLASH) begin
         s.value = SEXTET_SLASH;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

// File: hdl/b64d_front.sv
// Front part: accepts characters, tracks the group and builds queue entries.
`timescale 1ns / 1ps

module b64d_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_char_in,
   input  logic                    req_end_of_message,
   input  b64d_pkg::b64d_qstat_type qstat,
   output logic                    push,
   output b64d_pkg::b64d_entry_type entry
);
   import b64d_pkg::*;

   logic [1:0]      group_count_ff, group_count_in;
   logic [17:0]     accum_ff, accum_in;
   logic            stopped_ff, stopped_in;
   b64d_sextet_type sx;
   logic            accept;
   logic [1:0]      n_bytes;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign sx        = b64d_sextet(req_char_in);

   // Next group state and the bytes this character releases
   always_comb begin
      group_count_in = group_count_ff;
      accum_in       = accum_ff;
      stopped_in     = stopped_ff;
      n_bytes        = 2'd0;
      entry.bytes    = '0;
      if (!stopped_ff) begin
         if (!sx.ok) begin
            stopped_in = 1'b1;
         end else if (group_count_ff == 2'd3) begin
            entry.bytes    = {accum_ff, sx.value};
            n_bytes        = 2'd3;
            group_count_in = 2'd0;
            accum_in       = '0;
         end else begin
            accum_in       = {accum_ff[11:0], sx.value};
            group_count_in = group_count_ff + 2'd1;
         end
      end
      // Flush a partial group at message end
      if (req_end_of_message) begin
         if (group_count_in == 2'd2) begin
            entry.bytes = {accum_in[11:4], 16'h0000};
            n_bytes     = 2'd1;
         end else if (group_count_in == 2'd3) begin
            entry.bytes = {accum_in[17:10], accum_in[9:2], 8'h00};
            n_bytes     = 2'd2;
         end
         group_count_in = 2'd0;
         accum_in       = '0;
         stopped_in     = 1'b0;
      end
      entry.bare  = (n_bytes == 2'd0);
      entry.count = (n_bytes == 2'd0) ? 2'd1 : n_bytes;
      entry.last  = req_end_of_message;
   end

   assign push = accept && ((n_bytes != 2'd0) || req_end_of_message);

   // Group state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff <= 2'd0;
         accum_ff       <= '0;
         stopped_ff     <= 1'b0;
      end else if (accept) begin
         group_count_ff <= group_count_in;
         accum_ff       <= accum_in;
         stopped_ff     <= stopped_in;
      end
   end

endmodule

// File: hdl/b64d_queue.sv
// Short register queue of byte groups between the front and back parts.
`timescale 1ns / 1ps

module b64d_queue #(
   parameter int DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64d_pkg::b64d_entry_type push_entry,
   input  logic                     pop,
   output b64d_pkg::b64d_entry_type head,
   output b64d_pkg::b64d_qstat_type qstat
);
   import b64d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64d_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign qstat.full  = (count_ff == FULL_CNT);
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hdl/b64d_back.sv
// Back part: splits queued groups into single bytes behind an output register.
`timescale 1ns / 1ps

module b64d_back (
   input  logic                     clock,
   input  logic                     reset,
   input  b64d_pkg::b64d_entry_type head,
   input  b64d_pkg::b64d_qstat_type qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_message_end
);
   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       bvalid_ff, bvalid_in;
   logic       mend_ff, mend_in;
   logic       can_load, take, at_end;

   assign can_load = !valid_ff || !rsp_stall;
   assign take     = can_load && !qstat.empty;
   assign at_end   = (idx_ff == head.count - 2'd1);
   assign pop      = take && at_end;

   // Select the next byte of the head group
   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      bvalid_in = bvalid_ff;
      mend_in   = mend_ff;
      if (take) begin
         valid_in  = 1'b1;
         bvalid_in = !head.bare;
         mend_in   = head.last && at_end;
         case (idx_ff)
            2'd0:    data_in = head.bytes[23:16];
            2'd1:    data_in = head.bytes[15:8];
            default: data_in = head.bytes[7:0];
         endcase
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (can_load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload, no reset needed
   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      bvalid_ff <= bvalid_in;
      mend_ff   <= mend_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_message_end = mend_ff;

endmodule

// File: hdl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front, queue and back parts.
//
//  channel | direction | ports                                        | handshake
//  req     | in        | req_char_in, req_end_of_message              | req_valid / req_stall
//  rsp     | out       | rsp_data_byte, rsp_byte_valid, rsp_message_end | rsp_valid / rsp_stall
//
// One character is taken per cycle while req_stall is low; it leaves its bytes
// in the queue and the back part sends one byte per cycle while rsp_stall is
// low. A result passes through a queue slot and then the output register.
// req_stall rises only when the queue is full, set by a stalled result side.
// Reset is synchronous and empties the queue and clears the group state.
`timescale 1ns / 1ps

module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_message_end
);
   import b64d_pkg::*;

   b64d_entry_type push_entry, head;
   b64d_qstat_type qstat;
   logic           push, pop;

   b64d_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_in        (req_char_in),
      .req_end_of_message (req_end_of_message),
      .qstat              (qstat),
      .push               (push),
      .entry              (push_entry)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_message_end (rsp_message_end)
   );

endmodule

// File: hdl/b64d_checker.sv
// Port-level assertions for the base64 stream decoder and their bind.
`timescale 1ns / 1ps

module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_message_end
);

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_message_end))
      else $error("stalled result changed");

   // A result without a byte is only ever the end marker
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_message_end)
      else $error("bare result without message_end");

   // The end marker carries a zero byte
   a_bare_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_data_byte == 8'h00)
      else $error("bare result with non-zero byte");

   // Reset leaves no result pending
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // Reset leaves the request side ready
   a_reset_ready: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("request stalled straight after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

// File: tb/base64_result_checker.sv
// Checker for the base64 stream decoder: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module base64_result_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_message,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_message_end,
   output int         fail_count,
   output int         pending_count,
   output int         byte_count,
   output int         marker_count
);
   import b64d_pkg::*;

   // Bit 6 set marks a character outside the alphabet ('=' included)
   localparam logic [6:0] SEXTET_NONE = 7'h40;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_end;
   } decoded_result_type;

   decoded_result_type expected_results[$];

   // Predicted decoder state
   logic [1:0]  held_sextets;
   logic [17:0] sextet_bits;
   logic        stopped;

   function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) return {1'b0, 6'(ch - CHAR_UPPER_A)};
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) return {1'b0, 6'(ch - CHAR_LOWER_A + 26)};
      if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) return {1'b0, 6'(ch - CHAR_DIGIT_0 + 52)};
      if (ch == CHAR_PLUS) return {1'b0, SEXTET_PLUS};
      if (ch == CHAR_SLASH) return {1'b0, SEXTET_SLASH};
      return SEXTET_NONE;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch in %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   // Work out the bytes one accepted character produces and queue them
   task automatic decode_char(input logic [7:0] ch, input logic last);
      logic [6:0]  sx;
      logic [23:0] group;
      logic [7:0]  out_bytes [3];
      int          n;
      n  = 0;
      sx = char_to_sextet(ch);
      if (!stopped) begin
         if (sx[6]) begin
            stopped = 1'b1;
         end else if (held_sextets == 2'd3) begin
            group        = {sextet_bits, sx[5:0]};
            out_bytes[0] = group[23:16];
            out_bytes[1] = group[15:8];
            out_bytes[2] = group[7:0];
            n            = 3;
            held_sextets = '0;
            sextet_bits  = '0;
         end else begin
            sextet_bits  = {sextet_bits[11:0], sx[5:0]};
            held_sextets = held_sextets + 2'd1;
         end
      end
      // Flush a partial group at message end
      if (last) begin
         case (held_sextets)
            2'd2: begin
               out_bytes[0] = sextet_bits[11:4];
               n = 1;
            end
            2'd3: begin
               out_bytes[0] = sextet_bits[17:10];
               out_bytes[1] = sextet_bits[9:2];
               n = 2;
            end
            default: ;
         endcase
         held_sextets = '0;
         sextet_bits  = '0;
         stopped      = 1'b0;
         if (n == 0)
            expected_results.insert(expected_results.size(),
                                    decoded_result_type'{8'h00, 1'b0, 1'b1});
      end
      for (int k = 0; k < n; k++)
         expected_results.insert(expected_results.size(),
                                 decoded_result_type'{out_bytes[k], 1'b1, last && (k == n - 1)});
   endtask

   // Compare each result transaction, then predict from each request transaction
   always @(posedge clock) begin : watch_channels
      decoded_result_type want;
      if (reset) begin
         expected_results.delete();
         held_sextets = '0;
         sextet_bits  = '0;
         stopped      = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_data_byte, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data_byte !== want.data_byte)
                  report_mismatch("data_byte", rsp_data_byte, want.data_byte);
               if (rsp_byte_valid !== want.byte_valid)
                  report_mismatch("byte_valid", rsp_byte_valid, want.byte_valid);
               if (rsp_message_end !== want.message_end)
                  report_mismatch("message_end", rsp_message_end, want.message_end);
               if (want.byte_valid) byte_count++;
               else marker_count++;
            end
         end
         if (req_valid && !req_stall) decode_char(req_char_in, req_end_of_message);
      end
      pending_count = expected_results.size();
   end

endmodule

// File: tb/testbench.sv
// Top of the base64 stream decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import b64d_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int RANDOM_ITEMS = 205;
   localparam int SETTLE_WAIT  = 10;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_in;
   logic       req_end_of_message;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_message_end;

   int fail_count;
   int pending_count;
   int byte_count;
   int marker_count;
   int idle_cycles;
   int idle_mode;      // 0: no gaps or stalls, 1: random gaps and stalls
   int message_count;
   int item_count;
   int random_items;

   base64_stream_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_in        (req_char_in),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_message_end    (rsp_message_end)
   );

   base64_result_checker result_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_in        (req_char_in),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_message_end    (rsp_message_end),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .byte_count         (byte_count),
      .marker_count       (marker_count)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short idle runs, a few long ones
   function automatic int pick_idle_run();
      int r;
      r = $urandom_range(0, 99);
      if (idle_mode == 0 || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side back-pressure, changed at the falling edge
   initial begin : stall_gen
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_idle_run();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // Watchdog: too long without any transaction ends the run
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
            $display("[base64_stream_decoder] ERROR");
            $finish;
         end
      end
   end

   function automatic logic [7:0] alphabet_char(input int idx);
      if (idx < 26) return 8'(CHAR_UPPER_A + idx);
      if (idx < 52) return 8'(CHAR_LOWER_A + idx - 26);
      if (idx < 62) return 8'(CHAR_DIGIT_0 + idx - 52);
      if (idx == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // Send one character; called and returns at a falling edge
   task automatic send_char(input logic [7:0] ch, input logic last);
      int gap;
      gap = pick_idle_run();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_char_in        <= ch;
      req_end_of_message <= last;
      do @(posedge clock); while (req_stall);
      item_count++;
      @(negedge clock);
   endtask

   task automatic send_message(input logic [7:0] chars[$]);
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
      message_count++;
   endtask

   task automatic send_text(input string s);
      logic [7:0] chars[$];
      for (int i = 0; i < s.len(); i++) chars.insert(chars.size(), s[i]);
      send_message(chars);
   endtask

   // Hold the sender off until every predicted result has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Random message: mostly proper encodings, some broken, some noise
   task automatic build_message(output logic [7:0] chars[$]);
      int kind;
      int n;
      chars = {};
      kind  = $urandom_range(0, 99);
      if (kind < 70) begin
         n = $urandom_range(1, 12);
         repeat (n) chars.insert(chars.size(), alphabet_char($urandom_range(0, 63)));
         if (n % 4 == 2 && $urandom_range(0, 1)) chars = {chars, "=", "="};
         if (n % 4 == 3 && $urandom_range(0, 1)) chars.insert(chars.size(), "=");
      end else if (kind < 85) begin
         repeat ($urandom_range(0, 7))
            chars.insert(chars.size(), alphabet_char($urandom_range(0, 63)));
         chars.insert(chars.size(), 8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 4)) chars.insert(chars.size(), 8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) chars.insert(chars.size(), 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      logic [7:0] chars[$];
      req_valid          = 1'b0;
      req_char_in        = '0;
      req_end_of_message = 1'b0;
      idle_mode          = 1;
      idle_cycles        = 0;
      message_count      = 0;
      item_count         = 0;
      random_items       = 0;
      reset              = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full group, alphabet extremes, padding, lone sextet, bytes outside the alphabet
      send_text("TWFu");
      send_text("AZaz09+/");
      send_text("QQ==");
      send_text("QUI=");
      send_text("Q");
      send_message({8'h80, 8'hFF});
      send_message({8'h00, 8'h7F});
      wait_drained();

      // Random messages with changing idle behaviour
      while (random_items < RANDOM_ITEMS) begin
         idle_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
         build_message(chars);
         send_message(chars);
         random_items += chars.size();
         if (message_count % 15 == 0) wait_drained();
      end

      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Sent %0d messages, %0d characters (%0d random).",
               message_count, item_count, random_items);
      $display("Checked %0d decoded bytes and %0d bare end markers.", byte_count, marker_count);
      if (fail_count == 0) begin
         $display("[base64_stream_decoder] OK");
      end else begin
         $display("[base64_stream_decoder] ERROR");
      end
      $finish;
   end

endmodule
